// ===== rtl/quaternion_arith_unit_assert.svh =====
// Assertion macros for the quaternion arithmetic unit.
// Expects i_clk and i_rst_n in the scope of the including module.
`ifndef QUATERNION_ARITH_UNIT_ASSERT_SVH
`define QUATERNION_ARITH_UNIT_ASSERT_SVH

// same-cycle implication
`define QAU_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QAU_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qau_pkg.sv =====
// Shared types of the quaternion arithmetic unit.
// No dependencies.
package qau_pkg;

    typedef enum logic [3:0] {
        OP_QMUL  = 4'd0,
        OP_QCMUL = 4'd1,
        OP_CQMUL = 4'd2,
        OP_QDIV  = 4'd3,
        OP_QCDIV = 4'd4,
        OP_CQDIV = 4'd5,
        OP_CONJ  = 4'd6,
        OP_NORM2 = 4'd7,
        OP_INV   = 4'd8
    } t_op;

    // per-word control that rides down the pipeline
    typedef struct packed {
        logic div;    // result is a quotient by the norm
        logic dz;     // divisor norm was zero
        logic undef;  // opcode not defined
    } t_ctl;

endpackage

// ===== rtl/qau_if.sv =====
// Valid/ready channels of the quaternion arithmetic unit.
// No dependencies.
interface qau_req_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic [3:0]          opcode;
    logic signed [W-1:0] a_real;
    logic signed [W-1:0] a_i;
    logic signed [W-1:0] a_j;
    logic signed [W-1:0] a_k;
    logic signed [W-1:0] b_real;
    logic signed [W-1:0] b_i;
    logic signed [W-1:0] b_j;
    logic signed [W-1:0] b_k;

    modport source (output valid, opcode, a_real, a_i, a_j, a_k,
                    b_real, b_i, b_j, b_k, input ready);
    modport sink   (input valid, opcode, a_real, a_i, a_j, a_k,
                    b_real, b_i, b_j, b_k, output ready);
endinterface

interface qau_rsp_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] r_real;
    logic signed [W-1:0] r_i;
    logic signed [W-1:0] r_j;
    logic signed [W-1:0] r_k;
    logic                divide_by_zero;
    logic                saturated;

    modport source (output valid, r_real, r_i, r_j, r_k, divide_by_zero,
                    saturated, input ready);
    modport sink   (input valid, r_real, r_i, r_j, r_k, divide_by_zero,
                    saturated, output ready);
endinterface

// ===== rtl/qau_div_step.sv =====
// One restoring-division stage: one quotient bit for all four components.
// Depends on qau_pkg.
module qau_div_step #(
    parameter int W   = 32,
    parameter int MW  = 65,
    parameter int DW  = 97,
    parameter int BIT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  qau_pkg::t_ctl        i_ctl,
    input  logic [3:0]           i_neg,
    input  logic [3:0]           i_ovf,
    input  logic [MW-1:0]        i_n,
    input  logic [3:0][DW-1:0]   i_rem,
    input  logic [3:0][W-1:0]    i_q,
    output qau_pkg::t_ctl        o_ctl,
    output logic [3:0]           o_neg,
    output logic [3:0]           o_ovf,
    output logic [MW-1:0]        o_n,
    output logic [3:0][DW-1:0]   o_rem,
    output logic [3:0][W-1:0]    o_q
);
    import qau_pkg::*;

    localparam logic [W-1:0] QBIT = {{(W-1){1'b0}}, 1'b1} << BIT;

    t_ctl              r_ctl;
    logic [3:0]        r_neg;
    logic [3:0]        r_ovf;
    logic [MW-1:0]     r_n;
    logic [3:0][DW-1:0] r_rem;
    logic [3:0][W-1:0] r_q;
    logic [DW-1:0]     w_dsr;

    assign w_dsr = DW'(i_n) << BIT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_neg <= i_neg;
            r_ovf <= i_ovf;
            r_n   <= i_n;
            for (int c = 0; c < 4; c++) begin
                if (i_ctl.div && i_rem[c] >= w_dsr) begin
                    r_rem[c] <= i_rem[c] - w_dsr;
                    r_q[c]   <= i_q[c] | QBIT;
                end else begin
                    r_rem[c] <= i_rem[c];
                    r_q[c]   <= i_q[c];
                end
            end
        end
    end

    assign o_ctl = r_ctl;
    assign o_neg = r_neg;
    assign o_ovf = r_ovf;
    assign o_n   = r_n;
    assign o_rem = r_rem;
    assign o_q   = r_q;

endmodule

// ===== rtl/quaternion_arith_unit.sv =====
// Quaternion arithmetic unit, signed fixed point (COMP_WIDTH bits, FRAC_BITS fraction).
// One word enters per cycle while input ready is high; results leave in order, through
// multiply, sum, magnitude, rounding/numerator, one stage per quotient bit of the norm
// division (a 3*COMP_WIDTH+1 bit compare-subtract per component), then saturation into
// the output register. Every opcode takes the same path. Stalls collapse bubbles, so
// input ready drops only when all stages are full.
// Depends on qau_pkg, qau_if, qau_div_step and quaternion_arith_unit_assert.svh.
module quaternion_arith_unit #(
    parameter int COMP_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qau_req_if.sink   i_req,
    qau_rsp_if.source o_rsp
);
    import qau_pkg::*;

    localparam int W   = COMP_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * W;
    localparam int SW  = 2 * W + 2;
    localparam int MW  = 2 * W + 1;
    localparam int DW  = 3 * W + 1;
    localparam int NST = W + 5;

    localparam logic signed [W-1:0] ONE_Q = {{(W-1){1'b0}}, 1'b1} << F;
    localparam logic [MW:0]         HALF  = {{MW{1'b0}}, 1'b1} << (F - 1);

    // stall control: a stage holds only when it and everything after it is full
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;

    for (genvar k = 0; k < NST; k++) begin : g_en
        assign w_en[k] = ~(&r_vld[NST-1:k]) | o_rsp.ready;
    end

    assign i_req.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_req.valid;
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ---- decode operands
    logic signed [W-1:0] w_a [4];
    logic signed [W-1:0] w_x [4];
    logic signed [W-1:0] w_y [4];
    logic w_cj, w_div, w_undef, w_nrm;

    assign w_a[0] = i_req.a_real;
    assign w_a[1] = i_req.a_i;
    assign w_a[2] = i_req.a_j;
    assign w_a[3] = i_req.a_k;

    always_comb begin
        w_x[0] = i_req.a_real;
        w_x[1] = i_req.a_i;
        w_x[2] = i_req.a_j;
        w_x[3] = i_req.a_k;
        w_y[0] = i_req.b_real;
        w_y[1] = i_req.b_i;
        w_y[2] = i_req.b_j;
        w_y[3] = i_req.b_k;
        w_cj    = 1'b0;
        w_div   = 1'b0;
        w_undef = 1'b0;
        w_nrm   = 1'b0;
        case (t_op'(i_req.opcode))
            OP_QMUL: ;
            OP_QCMUL: begin
                w_y[2] = '0;
                w_y[3] = '0;
            end
            OP_CQMUL: begin
                w_x[2] = '0;
                w_x[3] = '0;
            end
            OP_QDIV: begin
                w_div = 1'b1;
                w_cj  = 1'b1;
            end
            OP_QCDIV: begin
                w_y[2] = '0;
                w_y[3] = '0;
                w_div  = 1'b1;
                w_cj   = 1'b1;
            end
            OP_CQDIV: begin
                w_x[2] = '0;
                w_x[3] = '0;
                w_div  = 1'b1;
                w_cj   = 1'b1;
            end
            OP_CONJ, OP_INV: begin
                // 1 * conj(a), scaled by the norm for the inverse
                w_x[0] = ONE_Q;
                w_x[1] = '0;
                w_x[2] = '0;
                w_x[3] = '0;
                for (int i = 0; i < 4; i++) w_y[i] = w_a[i];
                w_cj  = 1'b1;
                w_div = (t_op'(i_req.opcode) == OP_INV);
            end
            OP_NORM2: begin
                for (int i = 0; i < 4; i++) begin
                    w_x[i] = '0;
                    w_y[i] = w_a[i];
                end
                w_nrm = 1'b1;
            end
            default: w_undef = 1'b1;
        endcase
    end

    // ---- stage 1: partial products and squares
    logic signed [PW-1:0] r_p  [4][4];
    logic signed [PW-1:0] r_sq [4];
    logic r_cj1, r_div1, r_undef1, r_nrm1;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) r_p[i][j] <= PW'(w_x[i]) * PW'(w_y[j]);
                r_sq[i] <= PW'(w_y[i]) * PW'(w_y[i]);
            end
            r_cj1    <= w_cj;
            r_div1   <= w_div;
            r_undef1 <= w_undef;
            r_nrm1   <= w_nrm;
        end
    end

    // ---- stage 2: Hamilton sums (or the squared norm for NORM2), conj flips every term on y_i, y_j, y_k
    function automatic logic signed [SW-1:0] tm(input logic signed [PW-1:0] p,
                                                 input logic ng);
        logic signed [SW-1:0] e;
        e  = SW'(p);
        tm = ng ? -e : e;
    endfunction

    logic signed [SW-1:0] w_s [4];
    logic [MW-1:0]        w_n;

    always_comb begin
        w_n = MW'($unsigned(r_sq[0])) + MW'($unsigned(r_sq[1]))
            + MW'($unsigned(r_sq[2])) + MW'($unsigned(r_sq[3]));
        w_s[0] = tm(r_p[0][0], 1'b0) + tm(r_p[1][1], ~r_cj1)
               + tm(r_p[2][2], ~r_cj1) + tm(r_p[3][3], ~r_cj1);
        w_s[1] = tm(r_p[0][1], r_cj1) + tm(r_p[1][0], 1'b0)
               + tm(r_p[2][3], r_cj1) + tm(r_p[3][2], ~r_cj1);
        w_s[2] = tm(r_p[0][2], r_cj1) + tm(r_p[2][0], 1'b0)
               + tm(r_p[1][3], ~r_cj1) + tm(r_p[3][1], r_cj1);
        w_s[3] = tm(r_p[0][3], r_cj1) + tm(r_p[3][0], 1'b0)
               + tm(r_p[1][2], r_cj1) + tm(r_p[2][1], ~r_cj1);
        if (r_nrm1) begin
            w_s[0] = SW'(w_n);
            w_s[1] = '0;
            w_s[2] = '0;
            w_s[3] = '0;
        end
    end

    logic signed [SW-1:0] r_s [4];
    logic [MW-1:0]        r_n2;
    logic                 r_div2, r_undef2;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int c = 0; c < 4; c++) r_s[c] <= w_s[c];
            r_n2     <= w_n;
            r_div2   <= r_div1;
            r_undef2 <= r_undef1;
        end
    end

    // ---- stage 3: sign and magnitude
    logic [3:0]        r_neg3;
    logic [MW-1:0]     r_mag3 [4];
    logic [MW-1:0]     r_n3;
    t_ctl              r_ctl3;
    logic signed [SW-1:0] w_abs [4];

    always_comb begin
        for (int c = 0; c < 4; c++) w_abs[c] = r_s[c][SW-1] ? -r_s[c] : r_s[c];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int c = 0; c < 4; c++) begin
                r_neg3[c] <= r_s[c][SW-1];
                r_mag3[c] <= w_abs[c][MW-1:0];
            end
            r_n3         <= r_n2;
            r_ctl3.div   <= r_div2;
            r_ctl3.dz    <= r_div2 && (r_n2 == '0);
            r_ctl3.undef <= r_undef2;
        end
    end

    // ---- stage 4: product rounding or quotient numerator, and overflow test
    logic [3:0][DW-1:0] w_rem [W+1];
    logic [3:0][W-1:0]  w_q   [W+1];
    logic [3:0]         w_neg [W+1];
    logic [3:0]         w_ovf [W+1];
    logic [MW-1:0]      w_nn  [W+1];
    t_ctl               w_ctl [W+1];

    logic [3:0][DW-1:0] r_rem4;
    logic [3:0][W-1:0]  r_q4;
    logic [3:0]         r_neg4;
    logic [3:0]         r_ovf4;
    logic [MW-1:0]      r_n4;
    t_ctl               r_ctl4;
    logic [MW:0]        w_rnd [4];
    logic [DW-1:0]      w_num [4];
    logic [DW-1:0]      w_top;

    always_comb begin
        w_top = DW'(r_n3) << W;
        for (int c = 0; c < 4; c++) begin
            w_rnd[c] = ({1'b0, r_mag3[c]} + HALF) >> F;
            w_num[c] = (DW'(r_mag3[c]) << F) + DW'(r_n3 >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            for (int c = 0; c < 4; c++) begin
                if (r_ctl3.div) begin
                    r_rem4[c] <= w_num[c];
                    r_q4[c]   <= '0;
                    r_ovf4[c] <= (w_num[c] >= w_top);
                end else begin
                    r_rem4[c] <= '0;
                    r_q4[c]   <= w_rnd[c][W-1:0];
                    r_ovf4[c] <= |w_rnd[c][MW:W];
                end
            end
            r_neg4 <= r_neg3;
            r_n4   <= r_n3;
            r_ctl4 <= r_ctl3;
        end
    end

    assign w_rem[0] = r_rem4;
    assign w_q[0]   = r_q4;
    assign w_neg[0] = r_neg4;
    assign w_ovf[0] = r_ovf4;
    assign w_nn[0]  = r_n4;
    assign w_ctl[0] = r_ctl4;

    // ---- division stages, MSB first
    for (genvar d = 1; d <= W; d++) begin : g_div
        qau_div_step #(
            .W   (W),
            .MW  (MW),
            .DW  (DW),
            .BIT (W - d)
        ) u_step (
            .i_clk (i_clk),
            .i_en  (w_en[3+d]),
            .i_ctl (w_ctl[d-1]),
            .i_neg (w_neg[d-1]),
            .i_ovf (w_ovf[d-1]),
            .i_n   (w_nn[d-1]),
            .i_rem (w_rem[d-1]),
            .i_q   (w_q[d-1]),
            .o_ctl (w_ctl[d]),
            .o_neg (w_neg[d]),
            .o_ovf (w_ovf[d]),
            .o_n   (w_nn[d]),
            .o_rem (w_rem[d]),
            .o_q   (w_q[d])
        );
    end

    // ---- output stage: clamp, sign, zero forcing
    logic [W-1:0]  w_lim [4];
    logic [W-1:0]  w_mg  [4];
    logic [W-1:0]  n_res [4];
    logic [3:0]    w_satc;
    logic          w_zero;
    logic [W-1:0]  r_res [4];
    logic          r_dz, r_sat;

    always_comb begin
        w_zero = w_ctl[W].dz || w_ctl[W].undef;
        for (int c = 0; c < 4; c++) begin
            w_lim[c]  = w_neg[W][c] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            w_satc[c] = w_ovf[W][c] || (w_q[W][c] > w_lim[c]);
            w_mg[c]   = w_satc[c] ? w_lim[c] : w_q[W][c];
            n_res[c]  = w_zero ? '0 : (w_neg[W][c] ? -w_mg[c] : w_mg[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NST-1]) begin
            for (int c = 0; c < 4; c++) r_res[c] <= n_res[c];
            r_dz  <= w_ctl[W].dz && !w_ctl[W].undef;
            r_sat <= !w_zero && (|w_satc);
        end
    end

    assign o_rsp.valid          = r_vld[NST-1];
    assign o_rsp.r_real         = r_res[0];
    assign o_rsp.r_i            = r_res[1];
    assign o_rsp.r_j            = r_res[2];
    assign o_rsp.r_k            = r_res[3];
    assign o_rsp.divide_by_zero = r_dz;
    assign o_rsp.saturated      = r_sat;

    // ---- assertions
    logic w_rsp_clean;

    assign w_rsp_clean = (o_rsp.r_real == '0) && (o_rsp.r_i == '0) && (o_rsp.r_j == '0)
                       && (o_rsp.r_k == '0) && !o_rsp.saturated;

`include "quaternion_arith_unit_assert.svh"

    `QAU_AST_IMP(a_dz_clean, o_rsp.valid && o_rsp.divide_by_zero, w_rsp_clean, "dz word not zero")
    `QAU_AST_IMP(a_ready_free, !o_rsp.valid || o_rsp.ready, i_req.ready, "input ready low")
    `QAU_AST_NXT(a_enter, i_req.valid && i_req.ready, r_vld[0], "accepted word lost at first stage")

endmodule

// ===== tb/tb_quaternion_arith_unit.sv =====
// Self-checking testbench of quaternion_arith_unit: random and directed words, scoreboard
// with its own Q16.16 quaternion predictor. Depends on qau_pkg, qau_if and the RTL.
module tb_quaternion_arith_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import qau_pkg::*;

    localparam int W = 32;
    localparam int F = 16;
    localparam logic [3:0] OP_UNDEF_LO = 4'd9;
    localparam logic [3:0] OP_UNDEF_HI = 4'd15;
    localparam logic signed [W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [W-1:0] Q_ONE = 32'sh0001_0000;

    typedef struct {
        logic [3:0]          op;
        logic signed [W-1:0] a[4];
        logic signed [W-1:0] b[4];
    } t_quat_word;

    typedef struct {
        logic [W-1:0] r[4];
        logic         dz;
        logic         sat;
    } t_quat_res;

    class quat_scoreboard;
        t_quat_res pending_res[$];
        int        fails;

        static function automatic logic [W-1:0] clamp(logic [127:0] m, bit neg,
                                                      inout bit sat);
            logic [127:0] lim;
            logic [127:0] t;
            lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (m > lim) begin
                sat = 1;
                m   = lim;
            end
            t = neg ? -m : m;
            return t[W-1:0];
        endfunction

        static function automatic logic [W-1:0] round_prod(logic signed [127:0] s,
                                                           inout bit sat);
            logic [127:0] m;
            m = s[127] ? -s : s;
            m = (m + (128'd1 << (F - 1))) >> F;
            return clamp(m, s[127], sat);
        endfunction

        static function automatic logic [W-1:0] round_quot(logic signed [127:0] s,
                                                           logic [127:0] n, inout bit sat);
            logic [127:0] m;
            m = s[127] ? -s : s;
            m = ((m << F) + (n >> 1)) / n;
            return clamp(m, s[127], sat);
        endfunction

        static function automatic t_quat_res compute(t_quat_word w);
            logic signed [127:0] x[4];
            logic signed [127:0] y[4];
            logic signed [127:0] s[4];
            logic [127:0]        n;
            bit                  div;
            bit                  good;
            bit                  sat;
            t_quat_res           res;
            div  = 0;
            good = 1;
            sat  = 0;
            n    = '0;
            for (int i = 0; i < 4; i++) begin
                x[i] = 128'(w.a[i]);
                y[i] = 128'(w.b[i]);
                res.r[i] = '0;
            end
            res.dz = 0;
            case (w.op)
                OP_QMUL, OP_NORM2: ;
                OP_QCMUL: begin y[2] = 0; y[3] = 0; end
                OP_CQMUL: begin x[2] = 0; x[3] = 0; end
                OP_QDIV: div = 1;
                OP_QCDIV: begin y[2] = 0; y[3] = 0; div = 1; end
                OP_CQDIV: begin x[2] = 0; x[3] = 0; div = 1; end
                OP_CONJ, OP_INV: begin
                    // unit times a (or conj(a) for conj): reuses the product path
                    for (int i = 0; i < 4; i++) y[i] = x[i];
                    x[0] = 128'(Q_ONE); x[1] = 0; x[2] = 0; x[3] = 0;
                    if (w.op == OP_CONJ) begin
                        y[1] = -y[1]; y[2] = -y[2]; y[3] = -y[3];
                    end
                    div = (w.op == OP_INV);
                end
                default: good = 0;
            endcase
            if (good && w.op == OP_NORM2) begin
                s[0] = x[0]*x[0] + x[1]*x[1] + x[2]*x[2] + x[3]*x[3];
                res.r[0] = round_prod(s[0], sat);
            end else if (good) begin
                if (div) begin
                    n = y[0]*y[0] + y[1]*y[1] + y[2]*y[2] + y[3]*y[3];
                    y[1] = -y[1]; y[2] = -y[2]; y[3] = -y[3];
                end
                if (div && n == 0) begin
                    res.dz = 1;
                end else begin
                    s[0] = x[0]*y[0] - x[1]*y[1] - x[2]*y[2] - x[3]*y[3];
                    s[1] = x[0]*y[1] + x[1]*y[0] + x[2]*y[3] - x[3]*y[2];
                    s[2] = x[0]*y[2] + x[2]*y[0] - x[1]*y[3] + x[3]*y[1];
                    s[3] = x[0]*y[3] + x[3]*y[0] + x[1]*y[2] - x[2]*y[1];
                    for (int i = 0; i < 4; i++)
                        res.r[i] = div ? round_quot(s[i], n, sat) : round_prod(s[i], sat);
                end
            end
            res.sat = sat;
            return res;
        endfunction

        function void note(t_quat_word w);
            pending_res.push_back(compute(w));
        endfunction

        function void check(t_quat_res got);
            t_quat_res want;
            bit        bad;
            if (pending_res.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected result word r=%h %h %h %h",
                                          got.r[0], got.r[1], got.r[2], got.r[3]);
                return;
            end
            want = pending_res.pop_front();
            bad  = (want.dz !== got.dz) || (want.sat !== got.sat);
            for (int i = 0; i < 4; i++) if (want.r[i] !== got.r[i]) bad = 1;
            if (bad) begin
                fails++;
                if (fails <= 10)
                    $display({"mismatch: exp r=%h %h %h %h dz=%b sat=%b, ",
                              "got r=%h %h %h %h dz=%b sat=%b"},
                             want.r[0], want.r[1], want.r[2], want.r[3], want.dz, want.sat,
                             got.r[0], got.r[1], got.r[2], got.r[3], got.dz, got.sat);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    qau_req_if #(W) req();
    qau_rsp_if #(W) rsp();
    quat_scoreboard sb = new();
    bit src_quiet;
    bit snk_quiet;

    quaternion_arith_unit #(.COMP_WIDTH(W), .FRAC_BITS(F)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    initial i_clk = 0;
    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    function automatic logic signed [W-1:0] rand_comp();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $signed($urandom()) >>> 12;
            2: return $signed($urandom()) >>> 6;
            3: case ($urandom_range(0, 4))
                   0: return Q_MIN;
                   1: return Q_MAX;
                   2: return 0;
                   3: return Q_ONE;
                   default: return -Q_ONE;
               endcase
            default: return $signed($urandom()) >>> 20;
        endcase
    endfunction

    function automatic t_quat_word rand_word(logic [3:0] op);
        t_quat_word w;
        w.op = op;
        for (int i = 0; i < 4; i++) begin
            w.a[i] = rand_comp();
            w.b[i] = rand_comp();
        end
        return w;
    endfunction

    task automatic send_word(t_quat_word w);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        req.opcode <= w.op;
        req.a_real <= w.a[0]; req.a_i <= w.a[1]; req.a_j <= w.a[2]; req.a_k <= w.a[3];
        req.b_real <= w.b[0]; req.b_i <= w.b[1]; req.b_j <= w.b[2]; req.b_k <= w.b[3];
        req.valid  <= 1;
        do @(posedge i_clk); while (!req.ready);
        sb.note(w);
    endtask

    task automatic drain();
        req.valid <= 0;
        while (sb.pending_res.size() != 0) @(posedge i_clk);
    endtask

    // result side: random stall per word, quiet stretches now and then
    initial begin
        t_quat_res got;
        int        stall;
        rsp.ready <= 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0) snk_quiet = !snk_quiet;
            stall = snk_quiet ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                rsp.ready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            rsp.ready <= 1;
            do @(posedge i_clk); while (!rsp.valid);
            got.r[0] = rsp.r_real; got.r[1] = rsp.r_i;
            got.r[2] = rsp.r_j;    got.r[3] = rsp.r_k;
            got.dz   = rsp.divide_by_zero;
            got.sat  = rsp.saturated;
            sb.check(got);
        end
    end

    initial begin
        #2ms;
        $display("tb_quaternion_arith_unit: FAIL");
        $finish;
    end

    initial begin
        t_quat_word w;
        int         k;
        i_rst_n <= 0;
        req.valid <= 0;
        req.opcode <= '0;
        req.a_real <= '0; req.a_i <= '0; req.a_j <= '0; req.a_k <= '0;
        req.b_real <= '0; req.b_i <= '0; req.b_j <= '0; req.b_k <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // every defined opcode once with random content
        for (int op = OP_QMUL; op <= OP_INV; op++) send_word(rand_word(4'(op)));
        // zero divisors: full, real and i parts zero (j, k masked by QCDIV), zero inverse
        w = rand_word(OP_QDIV);  w.b = '{0, 0, 0, 0};          send_word(w);
        w = rand_word(OP_QCDIV); w.b = '{0, 0, Q_ONE, Q_MAX};  send_word(w);
        w = rand_word(OP_CQDIV); w.b = '{0, 0, 0, 0};          send_word(w);
        w = rand_word(OP_INV);   w.a = '{0, 0, 0, 0};          send_word(w);
        // extremes, saturation, conjugate of the most negative value
        w = rand_word(OP_QMUL);  w.a = '{Q_MAX, Q_MAX, Q_MAX, Q_MAX};
                                 w.b = '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}; send_word(w);
        w = rand_word(OP_QMUL);  w.a = '{Q_MIN, Q_MIN, Q_MIN, Q_MIN};
                                 w.b = '{Q_MIN, Q_MAX, Q_MIN, Q_MAX}; send_word(w);
        w = rand_word(OP_CONJ);  w.a = '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}; send_word(w);
        w = rand_word(OP_NORM2); w.a = '{Q_MAX, Q_MIN, Q_MAX, Q_MIN}; send_word(w);
        w = rand_word(OP_INV);   w.a = '{1, 0, 0, 0};                 send_word(w);
        w = rand_word(OP_QDIV);  w.a = '{Q_MAX, Q_MIN, Q_MAX, Q_MIN};
                                 w.b = '{1, 0, 0, 0};                 send_word(w);
        w = rand_word(OP_QCMUL); w.a = '{Q_ONE, 0, 0, 0};
                                 w.b = '{Q_ONE, Q_ONE, Q_MAX, Q_MIN}; send_word(w);
        w = rand_word(OP_CQMUL); w.a = '{Q_ONE, -Q_ONE, Q_MAX, Q_MIN}; send_word(w);
        send_word(rand_word(OP_UNDEF_LO));
        send_word(rand_word(OP_UNDEF_HI));

        // let the pipeline empty before the random part
        drain();

        for (k = 0; k < 700; k++) begin
            if ($urandom_range(0, 99) == 0) src_quiet = !src_quiet;
            if ($urandom_range(0, 19) == 0)
                w = rand_word(4'($urandom_range(0, 15)));
            else
                w = rand_word(4'($urandom_range(OP_QMUL, OP_INV)));
            if ($urandom_range(0, 24) == 0) begin
                w.b = '{0, 0, $urandom(), $urandom()};
                w.a[0] = 0; w.a[1] = 0;
            end
            send_word(w);
            if (k == 350) drain();
        end
        drain();
        repeat (60) @(posedge i_clk);

        if (sb.fails == 0)
            $display("tb_quaternion_arith_unit: PASS");
        else
            $display("tb_quaternion_arith_unit: FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/qau_pkg.sv
rtl/qau_if.sv
rtl/qau_div_step.sv
rtl/quaternion_arith_unit.sv
tb/tb_quaternion_arith_unit.sv
